// File: hdl/obb_separating_axis_test_top_assert.svh
// assertion macros for the box-pair separating-axis test block
`ifndef OBB_SEPARATING_AXIS_TEST_TOP_ASSERT_SVH
`define OBB_SEPARATING_AXIS_TEST_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// implication checked at every clock edge outside reset
`define OBB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// condition in one cycle implies a consequence in the next cycle
`define OBB_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error(msg);

`else

`define OBB_ASSERT(lbl, clk, rstn, prop, msg)
`define OBB_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

// File: hdl/obb_sat_pkg.sv
// shared constants and tables for the box-pair separating-axis test
`default_nettype none

package obb_sat_pkg;

  // fixed-point formats
  localparam int COMPONENT_WIDTH        = 21;
  localparam int ROTATION_FRACTION_BITS = 19;

  // stream payload layout
  localparam int FIELD_WIDTH   = 63;
  localparam int NUM_FIELDS    = 6;
  localparam int S_TDATA_WIDTH = 384;
  localparam int M_TDATA_WIDTH = 8;

  // field positions inside the input tdata
  localparam int FLD_CENTER = 3;
  localparam int FLD_EXT_A  = 4;
  localparam int FLD_EXT_B  = 5;

  // epsilon register
  localparam int             EPS_WIDTH = 10;
  localparam logic [9:0]     EPS_RESET = 10'd1;

  // axes
  localparam int NUM_AXES   = 15;
  localparam int AXIS_WIDTH = 4;
  localparam int FIRST_EDGE = 6;

  // axis slot (number minus one) of the face axes of each box
  localparam int A_FACE_IDX [3] = '{0, 2, 3};
  localparam int B_FACE_IDX [3] = '{1, 4, 5};

  // cyclic successor and predecessor of a coordinate index
  localparam int NEXT3 [3] = '{1, 2, 0};
  localparam int PREV3 [3] = '{2, 0, 1};

  // internal stages before the output register
  localparam int NUM_STAGES = 4;

endpackage

`default_nettype wire

// File: hdl/obb_separating_axis_test_top.sv
// Oriented box pair separating-axis test, fully pipelined
//
// Input channel s_axis_*: one transfer carries a box pair, box B given in
// the frame of box A (rotation rows, center offset, half extents of A and B).
// Output channel m_axis_*: one transfer per input transfer, in order, with
// the first separating axis number 1..15 (0 when the boxes overlap) and an
// overlap flag.
// Configuration: cfg_we_i writes cfg_wdata_i into the epsilon register that
// widens every absolute rotation entry; write it only while the block is idle.
// Pipeline: five register stages (four compute stages plus the output
// register).
// Throughput: one box pair per cycle unless m_axis stalls; the four compute
// stages are the unpack, multiplier, adder and compare stages.
// Stall: every stage holds its item while the next one is full, so a stalled
// receiver fills bubbles first and then backs up into s_axis_tready; nothing
// is dropped or repeated.
// Reset: all stage valid bits and the output valid clear, epsilon returns to 1.
`default_nettype none

`include "obb_separating_axis_test_top_assert.svh"

module obb_separating_axis_test_top #(
  parameter int COMPONENT_WIDTH        = obb_sat_pkg::COMPONENT_WIDTH,
  parameter int ROTATION_FRACTION_BITS = obb_sat_pkg::ROTATION_FRACTION_BITS
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // config
  input  wire logic                                    cfg_we_i,
  input  wire logic [obb_sat_pkg::EPS_WIDTH-1:0]       cfg_wdata_i,
  // input stream
  input  wire logic                                    s_axis_tvalid,
  output      logic                                    s_axis_tready,
  // rot_row0, rot_row1, rot_row2, center_offset, extents_first,
  // extents_second (63 bits each), zero pad to 384
  input  wire logic [obb_sat_pkg::S_TDATA_WIDTH-1:0]   s_axis_tdata,
  // output stream
  output      logic                                    m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // separating_axis (4 bits), overlap (1 bit), zero pad to 8
  output      logic [obb_sat_pkg::M_TDATA_WIDTH-1:0]   m_axis_tdata
);

  import obb_sat_pkg::*;

  localparam int CW  = COMPONENT_WIDTH;
  localparam int RF  = ROTATION_FRACTION_BITS;
  // |R| + eps, one guard bit above the component
  localparam int FW  = CW + 1;
  localparam int UPW = CW + FW;
  localparam int SPW = 2 * CW;
  localparam int SHW = CW + RF + 1;
  localparam int MXW = (UPW > SHW) ? UPW : SHW;
  // room for four terms and a sign
  localparam int SW  = MXW + 3;

  // radius product, unsigned operands
  function automatic logic signed [SW-1:0] umul(input logic [CW-1:0] x,
                                                input logic [FW-1:0] y);
    logic [UPW-1:0] p;
    p = x * y;
    return $signed(SW'(p));
  endfunction

  // projection product, signed operands
  function automatic logic signed [SW-1:0] smul(input logic signed [CW-1:0] x,
                                                input logic signed [CW-1:0] y);
    logic signed [SPW-1:0] p;
    p = x * y;
    return SW'(p);
  endfunction

  // epsilon register
  logic [EPS_WIDTH-1:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_we_i) begin
      eps_q <= cfg_wdata_i;
    end
  end

  // stage enables, last one is the output register
  logic [NUM_STAGES-1:0] v_q;
  logic                  out_v_q;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = !out_v_q || m_axis_tready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (en[NUM_STAGES]) begin
        out_v_q <= v_q[NUM_STAGES-1];
      end
    end
  end

  // stage 1: unpack fields, absolute rotation plus epsilon
  logic signed [CW-1:0] r_d [3][3];
  logic        [FW-1:0] f_d [3][3];
  logic signed [CW-1:0] t_d [3];
  logic        [CW-1:0] a_d [3];
  logic        [CW-1:0] b_d [3];
  logic signed [CW-1:0] r_q [3][3];
  logic        [FW-1:0] f_q [3][3];
  logic signed [CW-1:0] t_q [3];
  logic        [CW-1:0] a_q [3];
  logic        [CW-1:0] b_q [3];

  always_comb begin
    logic [FW-1:0] ext;
    logic [FW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r_d[i][j] = $signed(s_axis_tdata[i*FIELD_WIDTH + j*CW +: CW]);
        ext       = {r_d[i][j][CW-1], r_d[i][j]};
        mag       = ext[FW-1] ? (~ext + 1'b1) : ext;
        f_d[i][j] = mag + FW'(eps_q);
      end
      t_d[i] = $signed(s_axis_tdata[FLD_CENTER*FIELD_WIDTH + i*CW +: CW]);
      a_d[i] = s_axis_tdata[FLD_EXT_A*FIELD_WIDTH + i*CW +: CW];
      b_d[i] = s_axis_tdata[FLD_EXT_B*FIELD_WIDTH + i*CW +: CW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r_q <= r_d;
      f_q <= f_d;
      t_q <= t_d;
      a_q <= a_d;
      b_q <= b_d;
    end
  end

  // stage 2: all products, grouped per axis
  logic signed [SW-1:0] rt_d [NUM_AXES][4];
  logic signed [SW-1:0] st_d [NUM_AXES][3];
  logic signed [SW-1:0] rt_q [NUM_AXES][4];
  logic signed [SW-1:0] st_q [NUM_AXES][3];

  always_comb begin
    int ka;
    int kb;
    int ke;
    for (int i = 0; i < 3; i++) begin
      // face axis i of box A
      ka = A_FACE_IDX[i];
      rt_d[ka][0] = $signed(SW'(a_q[i]) << RF);
      rt_d[ka][1] = umul(b_q[0], f_q[i][0]);
      rt_d[ka][2] = umul(b_q[1], f_q[i][1]);
      rt_d[ka][3] = umul(b_q[2], f_q[i][2]);
      st_d[ka][0] = SW'(t_q[i]) <<< RF;
      st_d[ka][1] = '0;
      st_d[ka][2] = '0;
      // face axis i of box B
      kb = B_FACE_IDX[i];
      rt_d[kb][0] = $signed(SW'(b_q[i]) << RF);
      rt_d[kb][1] = umul(a_q[0], f_q[0][i]);
      rt_d[kb][2] = umul(a_q[1], f_q[1][i]);
      rt_d[kb][3] = umul(a_q[2], f_q[2][i]);
      st_d[kb][0] = smul(t_q[0], r_q[0][i]);
      st_d[kb][1] = smul(t_q[1], r_q[1][i]);
      st_d[kb][2] = smul(t_q[2], r_q[2][i]);
      // cross products of A axis i with every B axis j
      for (int j = 0; j < 3; j++) begin
        ke = FIRST_EDGE + 3 * i + j;
        rt_d[ke][0] = umul(a_q[NEXT3[i]], f_q[PREV3[i]][j]);
        rt_d[ke][1] = umul(a_q[PREV3[i]], f_q[NEXT3[i]][j]);
        rt_d[ke][2] = umul(b_q[NEXT3[j]], f_q[i][PREV3[j]]);
        rt_d[ke][3] = umul(b_q[PREV3[j]], f_q[i][NEXT3[j]]);
        st_d[ke][0] = smul(t_q[PREV3[i]], r_q[NEXT3[i]][j]);
        st_d[ke][1] = smul(t_q[NEXT3[i]], r_q[PREV3[i]][j]);
        st_d[ke][2] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      rt_q <= rt_d;
      st_q <= st_d;
    end
  end

  // stage 3: radius sums and projected distances
  logic signed [SW-1:0] rsum_d [NUM_AXES];
  logic signed [SW-1:0] ssum_d [NUM_AXES];
  logic signed [SW-1:0] rsum_q [NUM_AXES];
  logic signed [SW-1:0] ssum_q [NUM_AXES];

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      rsum_d[k] = (rt_q[k][0] + rt_q[k][1]) + (rt_q[k][2] + rt_q[k][3]);
      if (k >= FIRST_EDGE) begin
        ssum_d[k] = st_q[k][0] - st_q[k][1];
      end else begin
        ssum_d[k] = st_q[k][0] + st_q[k][1] + st_q[k][2];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      rsum_q <= rsum_d;
      ssum_q <= ssum_d;
    end
  end

  // stage 4: |s| > r as s > r or s + r < 0
  logic [NUM_AXES-1:0] sep_d;
  logic [NUM_AXES-1:0] sep_q;

  always_comb begin
    logic signed [SW-1:0] sr;
    for (int k = 0; k < NUM_AXES; k++) begin
      sr       = ssum_q[k] + rsum_q[k];
      sep_d[k] = (ssum_q[k] > rsum_q[k]) || sr[SW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sep_q <= sep_d;
    end
  end

  // output register: lowest separating axis wins
  logic [AXIS_WIDTH-1:0] axis_d;
  logic [AXIS_WIDTH-1:0] axis_q;
  logic                  ovl_q;

  always_comb begin
    axis_d = '0;
    for (int k = NUM_AXES - 1; k >= 0; k--) begin
      if (sep_q[k]) begin
        axis_d = AXIS_WIDTH'(k + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES]) begin
      axis_q <= axis_d;
      ovl_q  <= ~|sep_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(M_TDATA_WIDTH - AXIS_WIDTH - 1){1'b0}}, ovl_q, axis_q};

  // checks
  `OBB_ASSERT(a_ready_low_full, clk_i, rst_ni,
    !s_axis_tready |-> (m_axis_tvalid && (&v_q)),
    "input stalled while a stage is empty")
  `OBB_ASSERT(a_overlap_flag, clk_i, rst_ni,
    m_axis_tvalid |-> (m_axis_tdata[AXIS_WIDTH] == (m_axis_tdata[AXIS_WIDTH-1:0] == '0)),
    "overlap flag disagrees with axis number")
  `OBB_ASSERT_NEXT(a_sep_reported, clk_i, rst_ni,
    v_q[NUM_STAGES-1] && en[NUM_STAGES] && (|sep_q),
    m_axis_tvalid && (m_axis_tdata[AXIS_WIDTH-1:0] != '0),
    "separating axis lost on the way to the output")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench for the box-pair separating-axis test block
module tb;
  import obb_sat_pkg::*;

  localparam int     LATENCY = 5;
  localparam longint UNITY   = longint'(1) << ROTATION_FRACTION_BITS;
  localparam longint COS45   = 370727;
  localparam longint CMAX    = (longint'(1) << (COMPONENT_WIDTH - 1)) - 1;
  localparam longint CMIN    = -(longint'(1) << (COMPONENT_WIDTH - 1));
  localparam longint EMAX    = (longint'(1) << COMPONENT_WIDTH) - 1;

  typedef logic [FIELD_WIDTH-1:0]   field_t;
  typedef logic [S_TDATA_WIDTH-1:0] pair_t;

  typedef struct packed {
    logic [AXIS_WIDTH-1:0] axis;
    logic                  overlap;
  } verdict_t;

  // expected verdicts for accepted box pairs, checked in order
  class sat_scoreboard;
    verdict_t             verdicts[$];
    logic [EPS_WIDTH-1:0] eps;
    int unsigned          failures;

    function new();
      eps      = EPS_RESET;
      failures = 0;
    endfunction

    function longint magnitude(longint x);
      return (x < 0) ? -x : x;
    endfunction

    // first axis along which the projected distance exceeds the radii
    function verdict_t first_axis(pair_t d);
      longint rot[3][3], fab[3][3], ctr[3], ea[3], eb[3];
      longint s, r;
      logic [COMPONENT_WIDTH-1:0]        comp;
      logic signed [COMPONENT_WIDTH-1:0] scomp;
      bit     hit[NUM_AXES+1];
      int     i1, i2, j1, j2, ax;
      verdict_t v;

      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          comp  = d[i*FIELD_WIDTH + k*COMPONENT_WIDTH +: COMPONENT_WIDTH];
          scomp = comp;
          rot[i][k] = longint'(scomp);
          fab[i][k] = magnitude(rot[i][k]) + longint'(eps);
        end
        comp   = d[FLD_CENTER*FIELD_WIDTH + i*COMPONENT_WIDTH +: COMPONENT_WIDTH];
        scomp  = comp;
        ctr[i] = longint'(scomp);
        ea[i]  = longint'(d[FLD_EXT_A*FIELD_WIDTH + i*COMPONENT_WIDTH +: COMPONENT_WIDTH]);
        eb[i]  = longint'(d[FLD_EXT_B*FIELD_WIDTH + i*COMPONENT_WIDTH +: COMPONENT_WIDTH]);
      end
      foreach (hit[n]) hit[n] = 1'b0;

      // face axes of box a
      for (int i = 0; i < 3; i++) begin
        s = ctr[i] * UNITY;
        r = ea[i] * UNITY;
        for (int j = 0; j < 3; j++) r += eb[j] * fab[i][j];
        hit[A_FACE_IDX[i] + 1] = magnitude(s) > r;
      end
      // face axes of box b
      for (int j = 0; j < 3; j++) begin
        s = 0;
        r = eb[j] * UNITY;
        for (int i = 0; i < 3; i++) begin
          s += ctr[i] * rot[i][j];
          r += ea[i] * fab[i][j];
        end
        hit[B_FACE_IDX[j] + 1] = magnitude(s) > r;
      end
      // edge cross products a_i x b_j
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          i1 = (i + 1) % 3;
          i2 = (i + 2) % 3;
          j1 = (j + 1) % 3;
          j2 = (j + 2) % 3;
          s  = ctr[i2] * rot[i1][j] - ctr[i1] * rot[i2][j];
          r  = ea[i1] * fab[i2][j] + ea[i2] * fab[i1][j]
             + eb[j1] * fab[i][j2] + eb[j2] * fab[i][j1];
          hit[FIRST_EDGE + 1 + 3*i + j] = magnitude(s) > r;
        end
      end

      ax = 0;
      for (int n = NUM_AXES; n >= 1; n--) if (hit[n]) ax = n;
      v.axis    = AXIS_WIDTH'(ax);
      v.overlap = (ax == 0);
      return v;
    endfunction

    function void note_pair(pair_t d);
      verdicts.push_back(first_axis(d));
    endfunction

    function void check_result(logic [M_TDATA_WIDTH-1:0] got);
      verdict_t w;
      if (verdicts.size() == 0) begin
        $error("result transfer %0h with no box pair pending", got);
        failures++;
        return;
      end
      w = verdicts.pop_front();
      if (got[AXIS_WIDTH-1:0] !== w.axis) begin
        $error("separating_axis: expected %0d, actual %0d", w.axis, got[AXIS_WIDTH-1:0]);
        failures++;
      end
      if (got[AXIS_WIDTH] !== w.overlap) begin
        $error("overlap: expected %0b, actual %0b", w.overlap, got[AXIS_WIDTH]);
        failures++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [EPS_WIDTH-1:0]     cfg_wdata_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [S_TDATA_WIDTH-1:0] s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [M_TDATA_WIDTH-1:0] m_axis_tdata;

  sat_scoreboard sb;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  obb_separating_axis_test_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: check each transfer, stall in changing patterns
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_tick % 5) >= 2;
    endcase
  end

  function field_t trio(longint x, longint y, longint z);
    return {z[COMPONENT_WIDTH-1:0], y[COMPONENT_WIDTH-1:0], x[COMPONENT_WIDTH-1:0]};
  endfunction

  function pair_t pack_pair(field_t r0, field_t r1, field_t r2, field_t t,
                            field_t ea, field_t eb);
    return {{(S_TDATA_WIDTH - NUM_FIELDS*FIELD_WIDTH){1'b0}}, eb, ea, t, r2, r1, r0};
  endfunction

  function real unit_rand();
    return real'($urandom) / 4294967296.0;
  endfunction

  function longint clamp_comp(longint v);
    if (v > CMAX) return CMAX;
    if (v < CMIN) return CMIN;
    return v;
  endfunction

  function longint pick_extent();
    if ($urandom_range(0, 15) == 0) return longint'($urandom_range(0, EMAX));
    return longint'($urandom_range(0, 1 << $urandom_range(6, 14)));
  endfunction

  // every bit of the six fields random
  function pair_t noise_pair();
    pair_t p;
    for (int w = 0; w < S_TDATA_WIDTH / 32; w++) p[w*32 +: 32] = $urandom;
    p[S_TDATA_WIDTH-1:NUM_FIELDS*FIELD_WIDTH] = '0;
    return p;
  endfunction

  // rotated box pair with centers near the contact distance
  function pair_t shaped_pair();
    real    ang[3], cs[3], sn[3], m[3][3], dir[3], len, ra, rb, reach;
    longint rq[3][3], ea[3], eb[3], t[3];
    int     kind;

    kind = $urandom_range(0, 9);
    for (int k = 0; k < 3; k++) begin
      if (kind == 0) ang[k] = 0.0;
      else if (kind == 1) ang[k] = $urandom_range(0, 3) * 1.5707963267948966;
      else ang[k] = unit_rand() * 6.283185307179586;
      cs[k] = $cos(ang[k]);
      sn[k] = $sin(ang[k]);
    end
    // z-y-x rotation
    m[0][0] = cs[2]*cs[1];
    m[0][1] = cs[2]*sn[1]*sn[0] - sn[2]*cs[0];
    m[0][2] = cs[2]*sn[1]*cs[0] + sn[2]*sn[0];
    m[1][0] = sn[2]*cs[1];
    m[1][1] = sn[2]*sn[1]*sn[0] + cs[2]*cs[0];
    m[1][2] = sn[2]*sn[1]*cs[0] - cs[2]*sn[0];
    m[2][0] = -sn[1];
    m[2][1] = cs[1]*sn[0];
    m[2][2] = cs[1]*cs[0];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rq[i][j] = longint'($rtoi(m[i][j] * real'(UNITY)));
        // occasionally skew the matrix a little
        if (kind == 9) rq[i][j] += longint'($urandom_range(0, 63)) - 32;
        rq[i][j] = clamp_comp(rq[i][j]);
      end
    end

    ra = 0.0;
    rb = 0.0;
    for (int k = 0; k < 3; k++) begin
      ea[k] = pick_extent();
      eb[k] = pick_extent();
      ra += real'(ea[k]) * real'(ea[k]);
      rb += real'(eb[k]) * real'(eb[k]);
      dir[k] = 2.0 * unit_rand() - 1.0;
    end
    len = $sqrt(dir[0]*dir[0] + dir[1]*dir[1] + dir[2]*dir[2]);
    if (len < 1.0e-3) begin
      dir[0] = 1.0;
      dir[1] = 0.0;
      dir[2] = 0.0;
      len    = 1.0;
    end
    reach = ($sqrt(ra) + $sqrt(rb)) * (0.2 + 1.1 * unit_rand());
    for (int k = 0; k < 3; k++) t[k] = clamp_comp(longint'($rtoi(dir[k] / len * reach)));

    return pack_pair(trio(rq[0][0], rq[0][1], rq[0][2]), trio(rq[1][0], rq[1][1], rq[1][2]),
                     trio(rq[2][0], rq[2][1], rq[2][2]), trio(t[0], t[1], t[2]),
                     trio(ea[0], ea[1], ea[2]), trio(eb[0], eb[1], eb[2]));
  endfunction

  function pair_t random_pair();
    if ($urandom_range(0, 4) == 0) return noise_pair();
    return shaped_pair();
  endfunction

  // one transfer, with bursts and gaps on the sending side
  task automatic send_pair(input pair_t d);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_pair(d);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.verdicts.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic set_epsilon(input logic [EPS_WIDTH-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.eps = v;
  endtask

  task automatic run_directed();
    field_t id0, id1, id2, rz0, rz1, rz2, cube, rmin;
    id0  = trio(UNITY, 0, 0);
    id1  = trio(0, UNITY, 0);
    id2  = trio(0, 0, UNITY);
    rz0  = trio(COS45, -COS45, 0);
    rz1  = trio(COS45, COS45, 0);
    rz2  = id2;
    cube = trio(256, 256, 256);
    rmin = trio(CMIN, CMIN, CMIN);
    // all zero and all one fields
    send_pair('0);
    send_pair(pack_pair('1, '1, '1, '1, '1, '1));
    // aligned boxes: concentric, touching, just apart on the +x, -x, +y and -z faces of a
    send_pair(pack_pair(id0, id1, id2, trio(0, 0, 0), cube, cube));
    send_pair(pack_pair(id0, id1, id2, trio(512, 0, 0), trio(256, 512, 768), cube));
    send_pair(pack_pair(id0, id1, id2, trio(513, 0, 0), trio(256, 512, 768), cube));
    send_pair(pack_pair(id0, id1, id2, trio(-513, 0, 0), trio(256, 512, 768), cube));
    send_pair(pack_pair(id0, id1, id2, trio(0, 768, 0), trio(256, 512, 768), cube));
    send_pair(pack_pair(id0, id1, id2, trio(0, 769, 0), trio(256, 512, 768), cube));
    send_pair(pack_pair(id0, id1, id2, trio(0, 0, -1025), trio(256, 512, 768), cube));
    // b turned 45 degrees about z, offset along its own x face
    send_pair(pack_pair(rz0, rz1, rz2, trio(543, 543, 0), cube, cube));
    send_pair(pack_pair(rz0, rz1, rz2, trio(400, 400, 0), cube, cube));
    // skewed and extreme matrices, offsets and extents
    send_pair(pack_pair(rmin, rmin, rmin, trio(CMAX, CMAX, CMAX), '0, '0));
    send_pair(pack_pair(rmin, rmin, rmin, trio(CMIN, CMIN, CMIN), '1, '1));
    send_pair(pack_pair(id0, id1, id2, trio(CMAX, CMAX, CMAX), '0, '0));
    send_pair(pack_pair(id0, id1, id2, trio(CMIN, 0, 0), trio(EMAX, EMAX, EMAX), '0));
    send_pair(pack_pair(trio(CMAX, CMIN, 0), trio(0, CMAX, CMIN), trio(CMIN, 0, CMAX),
                        trio(CMAX, CMIN, CMAX), trio(1 << 20, 1 << 20, 1 << 20),
                        trio(1 << 20, 0, 1 << 20)));
    repeat (4) send_pair(shaped_pair());
  endtask

  initial begin
    logic [EPS_WIDTH-1:0] eps_plan[4];
    sb = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // epsilon as after reset
    repeat (60) send_pair(random_pair());
    drain();

    // exact arithmetic with no widening, including the touching cases
    set_epsilon('0);
    run_directed();
    repeat (218) send_pair(random_pair());

    eps_plan = '{10'd1023, EPS_WIDTH'($urandom_range(2, 1022)), 10'd1,
                 EPS_WIDTH'($urandom_range(2, 1022))};
    foreach (eps_plan[p]) begin
      drain();
      set_epsilon(eps_plan[p]);
      repeat (218) send_pair(random_pair());
    end
    drain();

    if (sb.failures == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
